/* hw/rtl/dba_pkg.sv */
// shared types, codes and defaults for the dual bitmap allocator
`timescale 1ns / 1ps
package dba_pkg;

    localparam int WORD_W  = 32;
    localparam int WORD_AW = 5;

    localparam int DEF_INODE_COUNT = 256;
    localparam int DEF_BLOCK_COUNT = 1024;

    typedef logic [1:0] t_action;
    localparam t_action ACT_ALLOC  = 2'd0;
    localparam t_action ACT_FREE   = 2'd1;
    localparam t_action ACT_FORMAT = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    typedef struct packed {
        t_action     action;
        logic        pool;
        logic [9:0]  entry_index;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [16:0] granted;
        logic [8:0]  free_inodes;
        logic [10:0] free_blocks;
    } t_res;

endpackage

/* hw/rtl/dba_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module dba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* hw/rtl/dba_ffz.sv */
// find-first-zero priority encoder over one map word
`timescale 1ns / 1ps
module dba_ffz
    import dba_pkg::*;
(
    input  logic [WORD_W-1:0]  i_word,
    output logic               o_found,
    output logic [WORD_AW-1:0] o_pos
);

    always_comb begin
        o_found = 1'b0;
        o_pos   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                o_found = 1'b1;
                o_pos   = WORD_AW'(i);
            end
        end
    end

endmodule

/* hw/rtl/dual_bitmap_allocator.sv */
// top level: inode and data block bitmap pools with first-fit allocation
//
//  channel   ports                         timing
//  -------   ---------------------------   ---------------------------------
//  command   start, busy, i_cmd            taken when start & !busy
//  result    o_done, o_res                 one-cycle strobe, no back-pressure
//  config    i_cfg_we, i_cfg_wdata         data start sector, written at once
//
// allocate scans the chosen map one 32-bit word a cycle, up to its last word.
// free reads the word and writes it back; a range error or unused action is
// answered straight from idle. format and reset run a clearing pass over
// max(inode words, block words) map words (32 by default) with busy high;
// format then returns its word. results cannot be stalled; busy alone holds off commands.
`timescale 1ns / 1ps
module dual_bitmap_allocator
    import dba_pkg::*;
#(
    parameter int INODE_COUNT = DEF_INODE_COUNT,
    parameter int BLOCK_COUNT = DEF_BLOCK_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_cmd        i_cmd,
    output logic        o_done,
    output t_res        o_res,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    localparam int IWORDS = (INODE_COUNT + WORD_W - 1) / WORD_W;
    localparam int BWORDS = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
    localparam int IAW    = (IWORDS > 1) ? $clog2(IWORDS) : 1;
    localparam int BAW    = (BWORDS > 1) ? $clog2(BWORDS) : 1;
    localparam int AW     = (IAW > BAW) ? IAW : BAW;
    localparam int MAXW   = (IWORDS > BWORDS) ? IWORDS : BWORDS;
    localparam int ICW    = $clog2(INODE_COUNT + 1);
    localparam int BCW    = $clog2(BLOCK_COUNT + 1);
    localparam int ITAIL  = INODE_COUNT % WORD_W;
    localparam int BTAIL  = BLOCK_COUNT % WORD_W;
    localparam logic [WORD_W-1:0] ITAIL_MASK =
        (ITAIL == 0) ? '0 : ({WORD_W{1'b1}} << ITAIL);
    localparam logic [WORD_W-1:0] BTAIL_MASK =
        (BTAIL == 0) ? '0 : ({WORD_W{1'b1}} << BTAIL);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_FREE
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      r_daddr;
    logic               r_dv;
    logic               r_pool;
    logic [WORD_AW-1:0] r_bit;
    logic               r_fmt;
    logic [ICW-1:0]     r_icnt;
    logic [BCW-1:0]     r_bcnt;
    logic [15:0]        r_sector;
    logic [ICW-1:0]     n_icnt;
    logic [BCW-1:0]     n_bcnt;
    logic               n_done;

    logic [WORD_W-1:0]  i_rdata;
    logic [WORD_W-1:0]  b_rdata;
    logic [WORD_W-1:0]  dout;
    logic [WORD_W-1:0]  scan_word;
    logic               is_last;
    logic               found;
    logic [WORD_AW-1:0] pos;
    logic               i_we;
    logic               b_we;
    logic [AW-1:0]      w_addr;
    logic [WORD_W-1:0]  w_data;
    logic [31:0]        grant_idx;
    logic               cmd_range;

    assign busy = (r_state != S_IDLE);

    assign dout      = r_pool ? b_rdata : i_rdata;
    assign is_last   = r_pool ? (r_daddr == AW'(BWORDS - 1)) : (r_daddr == AW'(IWORDS - 1));
    assign scan_word = dout | (is_last ? (r_pool ? BTAIL_MASK : ITAIL_MASK) : '0);
    assign grant_idx = 32'({r_daddr, pos}) + (r_pool ? 32'(r_sector) : 32'd0);
    assign cmd_range = i_cmd.pool ? (32'(i_cmd.entry_index) >= 32'(BLOCK_COUNT))
                                  : (32'(i_cmd.entry_index) >= 32'(INODE_COUNT));

    dba_ffz u_ffz (
        .i_word  (scan_word),
        .o_found (found),
        .o_pos   (pos)
    );

    dba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (IWORDS)
    ) u_inode_map (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (w_addr[IAW-1:0]),
        .i_wdata (w_data),
        .i_raddr (r_addr[IAW-1:0]),
        .o_rdata (i_rdata)
    );

    dba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BWORDS)
    ) u_block_map (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (w_addr[BAW-1:0]),
        .i_wdata (w_data),
        .i_raddr (r_addr[BAW-1:0]),
        .o_rdata (b_rdata)
    );

    always_comb begin
        w_addr = r_daddr;
        w_data = dout;
        i_we   = 1'b0;
        b_we   = 1'b0;
        n_icnt = r_icnt;
        n_bcnt = r_bcnt;
        n_done = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_addr = r_addr;
                w_data = '0;
                i_we   = (32'(r_addr) < 32'(IWORDS));
                b_we   = (32'(r_addr) < 32'(BWORDS));
                n_done = r_fmt && (r_addr == AW'(MAXW - 1));
            end
            S_IDLE: begin
                if (start) begin
                    case (i_cmd.action)
                        ACT_ALLOC: begin
                        end
                        ACT_FREE: begin
                            n_done = cmd_range;
                        end
                        ACT_FORMAT: begin
                            n_icnt = ICW'(INODE_COUNT);
                            n_bcnt = BCW'(BLOCK_COUNT);
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                w_data = dout | (WORD_W'(1) << pos);
                n_done = r_dv && (found || is_last);
                if (r_dv && found) begin
                    i_we = !r_pool;
                    b_we = r_pool;
                    if (r_pool) begin
                        n_bcnt = r_bcnt - BCW'(1);
                    end else begin
                        n_icnt = r_icnt - ICW'(1);
                    end
                end
            end
            S_FREE: begin
                w_data = dout & ~(WORD_W'(1) << r_bit);
                n_done = r_dv;
                if (r_dv) begin
                    i_we = !r_pool;
                    b_we = r_pool;
                    if (dout[r_bit]) begin
                        if (r_pool) begin
                            n_bcnt = r_bcnt + BCW'(1);
                        end else begin
                            n_icnt = r_icnt + ICW'(1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_dv     <= 1'b0;
            r_fmt    <= 1'b0;
            r_icnt   <= ICW'(INODE_COUNT);
            r_bcnt   <= BCW'(BLOCK_COUNT);
            r_sector <= '0;
            o_done   <= 1'b0;
        end else begin
            o_done             <= n_done;
            o_res.free_inodes  <= 9'(n_icnt);
            o_res.free_blocks  <= 11'(n_bcnt);
            r_icnt             <= n_icnt;
            r_bcnt             <= n_bcnt;
            if (i_cfg_we) begin
                r_sector <= i_cfg_wdata;
            end
            case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == AW'(MAXW - 1)) begin
                        r_state <= S_IDLE;
                        if (r_fmt) begin
                            o_res.status  <= ST_OK;
                            o_res.granted <= '0;
                        end
                        r_fmt <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_pool <= i_cmd.pool;
                        r_bit  <= i_cmd.entry_index[WORD_AW-1:0];
                        r_dv   <= 1'b0;
                        case (i_cmd.action)
                            ACT_ALLOC: begin
                                r_addr  <= '0;
                                r_state <= S_ALLOC;
                            end
                            ACT_FREE: begin
                                if (cmd_range) begin
                                    o_res.status  <= ST_RANGE;
                                    o_res.granted <= '0;
                                end else begin
                                    r_addr  <= AW'(i_cmd.entry_index >> WORD_AW);
                                    r_state <= S_FREE;
                                end
                            end
                            ACT_FORMAT: begin
                                r_addr  <= '0;
                                r_fmt   <= 1'b1;
                                r_state <= S_CLEAR;
                            end
                            default: begin
                                o_res.status  <= ST_OK;
                                o_res.granted <= '0;
                            end
                        endcase
                    end
                end
                S_ALLOC: begin
                    r_daddr <= r_addr;
                    r_addr  <= r_addr + AW'(1);
                    r_dv    <= 1'b1;
                    if (r_dv) begin
                        if (found) begin
                            o_res.status  <= ST_OK;
                            o_res.granted <= grant_idx[16:0];
                            r_state       <= S_IDLE;
                        end else if (is_last) begin
                            o_res.status  <= ST_FULL;
                            o_res.granted <= '0;
                            r_state       <= S_IDLE;
                        end
                    end
                end
                S_FREE: begin
                    r_daddr <= r_addr;
                    r_dv    <= 1'b1;
                    if (r_dv) begin
                        o_res.status  <= ST_OK;
                        o_res.granted <= '0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
